// ===== rtl/iror_pkg.sv =====
// ----------------------------------------------------------------------------
// In-flight range overlap tracker: shared definitions
// Widths, codes and the job record that passes from the front end to the
// table engine.
// ----------------------------------------------------------------------------
package iror_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 64;
  localparam int unsigned START_W           = 48;
  localparam int unsigned LEN_W             = 25;
  localparam int unsigned END_W             = START_W + 1;
  localparam int unsigned STATUS_W          = 2;
  localparam int unsigned QUEUE_DEPTH       = 2;

  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_CONFLICT  = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_SCAN
  } back_state_e;

  typedef struct packed {
    op_e                op;
    logic [START_W-1:0] start;
    logic [END_W-1:0]   stop;
  } job_t;

endpackage

// ===== rtl/iror_in_if.sv =====
// ----------------------------------------------------------------------------
// In-flight range overlap tracker: request channel
// Carries one acquire or release request per beat.
// ----------------------------------------------------------------------------
interface iror_in_if import iror_pkg::*; ();

  logic               valid;
  logic               ready;
  logic               op;
  logic [START_W-1:0] offset;
  logic [LEN_W-1:0]   length;

  modport source (output valid, output op, output offset, output length, input ready);
  modport sink   (input valid, input op, input offset, input length, output ready);

endinterface

// ===== rtl/iror_out_if.sv =====
// ----------------------------------------------------------------------------
// In-flight range overlap tracker: response channel
// Carries one status code per beat.
// ----------------------------------------------------------------------------
interface iror_out_if import iror_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output status, input ready);
  modport sink   (input valid, input status, output ready);

endinterface

// ===== rtl/iror_front.sv =====
// ----------------------------------------------------------------------------
// In-flight range overlap tracker: front end
// Accepts request beats, decodes the operation and forms the exclusive end
// of the range, then offers the job to the queue from a register.
// ----------------------------------------------------------------------------
module iror_front import iror_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  iror_in_if.sink   in_i,
  output logic      job_valid_o,
  output job_t      job_o,
  input  logic      job_ready_i
);

  logic             job_valid_q;
  job_t             job_q;
  job_t             job_d;
  logic             accept;
  logic [LEN_W-1:0] len_eff;

  assign in_i.ready = !job_valid_q || job_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  // A zero length is taken as one byte, so every stored range is non-empty.
  assign len_eff = (in_i.length == '0) ? LEN_W'(1) : in_i.length;

  always_comb begin
    job_d.op    = op_e'(in_i.op);
    job_d.start = in_i.offset;
    job_d.stop  = END_W'(in_i.offset) + END_W'(len_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
    end else if (accept) begin
      job_valid_q <= 1'b1;
    end else if (job_ready_i) begin
      job_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q <= job_d;
    end
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

endmodule

// ===== rtl/iror_queue.sv =====
// ----------------------------------------------------------------------------
// In-flight range overlap tracker: job queue
// A short first-in first-out buffer that decouples the front end from the
// table engine.
// ----------------------------------------------------------------------------
module iror_queue import iror_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  job_t push_data_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  output job_t pop_data_o,
  input  logic pop_ready_i
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push;
  logic             pop;

  assign push_ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/iror_back.sv =====
// ----------------------------------------------------------------------------
// In-flight range overlap tracker: table engine
// Holds the range table in a memory, scans it one entry per cycle for each
// job, inserts or frees an entry and registers the status for the response.
// ----------------------------------------------------------------------------
module iror_back import iror_pkg::*; #(
  parameter int unsigned TableEntries = TABLE_ENTRIES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  input  job_t       job_i,
  output logic       job_ready_o,
  iror_out_if.source out_o
);

  localparam int unsigned IDX_W = $clog2(TableEntries);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TableEntries - 1);

  typedef struct packed {
    logic               valid;
    logic [START_W-1:0] start;
    logic [END_W-1:0]   stop;
  } entry_t;

  entry_t           mem_q [TableEntries];
  entry_t           rd_data_q;
  entry_t           wr_data;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_en;

  back_state_e      state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;
  logic             free_found_q, free_found_d;
  job_t             job_q;
  logic             job_load;
  logic             res_valid_q, res_valid_d;
  status_e          status_q, status_d;

  logic             hit_overlap;
  logic             hit_start;
  logic             is_last;

  assign hit_overlap = rd_data_q.valid
                    && ({1'b0, rd_data_q.start} < job_q.stop)
                    && ({1'b0, job_q.start} < rd_data_q.stop);
  assign hit_start   = rd_data_q.valid && (rd_data_q.start == job_q.start);
  assign is_last     = (idx_q == LAST_IDX);

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    free_idx_d   = free_idx_q;
    free_found_d = free_found_q;
    status_d     = status_q;
    res_valid_d  = res_valid_q && !out_o.ready;
    job_ready_o  = 1'b0;
    job_load     = 1'b0;
    rd_addr      = idx_q + IDX_W'(1);
    wr_en        = 1'b0;
    wr_addr      = idx_q;
    wr_data      = '{valid: 1'b0, start: job_q.start, stop: job_q.stop};

    unique case (state_q)
      BS_CLEAR: begin
        wr_en = 1'b1;
        idx_d = idx_q + IDX_W'(1);
        if (is_last) begin
          state_d = BS_IDLE;
          idx_d   = '0;
        end
      end
      BS_IDLE: begin
        job_ready_o = !res_valid_q || out_o.ready;
        rd_addr     = '0;
        if (job_valid_i && job_ready_o) begin
          job_load     = 1'b1;
          state_d      = BS_SCAN;
          idx_d        = '0;
          free_found_d = 1'b0;
        end
      end
      BS_SCAN: begin
        idx_d = idx_q + IDX_W'(1);
        if (job_q.op == OP_ACQUIRE) begin
          if (hit_overlap) begin
            status_d    = ST_CONFLICT;
            res_valid_d = 1'b1;
            state_d     = BS_IDLE;
          end else begin
            if (!rd_data_q.valid && !free_found_q) begin
              free_found_d = 1'b1;
              free_idx_d   = idx_q;
            end
            if (is_last) begin
              if (free_found_q || !rd_data_q.valid) begin
                wr_en         = 1'b1;
                wr_addr       = free_found_q ? free_idx_q : idx_q;
                wr_data.valid = 1'b1;
                status_d      = ST_OK;
              end else begin
                status_d = ST_FULL;
              end
              res_valid_d = 1'b1;
              state_d     = BS_IDLE;
            end
          end
        end else begin
          if (hit_start) begin
            wr_en       = 1'b1;
            status_d    = ST_OK;
            res_valid_d = 1'b1;
            state_d     = BS_IDLE;
          end else if (is_last) begin
            status_d    = ST_NOT_FOUND;
            res_valid_d = 1'b1;
            state_d     = BS_IDLE;
          end
        end
      end
      default: begin
        state_d = BS_CLEAR;
        idx_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BS_CLEAR;
      idx_q        <= '0;
      free_found_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      free_found_q <= free_found_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    free_idx_q <= free_idx_d;
    status_q   <= status_d;
    if (job_load) begin
      job_q <= job_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  assign out_o.valid  = res_valid_q;
  assign out_o.status = status_q;

`ifndef SYNTHESIS
  a_scan_result_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BS_SCAN) |-> !res_valid_q)
    else $error("Result register occupied during a table scan.");

  a_take_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_i && job_ready_o) |-> (state_q == BS_IDLE))
    else $error("Job taken outside the idle state.");

  a_insert_grants: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BS_SCAN && wr_en && wr_data.valid) |-> (status_d == ST_OK && res_valid_d))
    else $error("Entry inserted without a grant.");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BS_CLEAR) |-> (!res_valid_q && !job_ready_o))
    else $error("Activity during the clearing pass.");

  a_scan_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(state_q == BS_SCAN) |-> res_valid_q)
    else $error("Scan ended without a result.");
`endif

endmodule

// ===== rtl/inflight_range_overlap_tracker_core.sv =====
// ----------------------------------------------------------------------------
// In-flight range overlap tracker
// Keeps a table of non-overlapping byte ranges, grants or refuses acquire
// requests and frees ranges on release requests.
// ----------------------------------------------------------------------------
// Usage:
// A request beat on in_i carries op (0 acquire, 1 release), a 48-bit start
// offset and a 25-bit length. Each request yields exactly one response beat
// on out_o with a status: 0 granted or released, 1 overlap conflict,
// 2 table full, 3 release not found.
// The table engine reads its memory one entry per cycle and takes a new
// job only once the scan of the last one has ended (a conflict or a release
// hit ends the scan early). A request passes through the front-end
// register, the queue and the engine's job register; after its scan the
// response beat comes from the status register.
// After reset the engine clears the table memory in one pass over every
// entry; requests are buffered by the front end and queue meanwhile.
// While the receiver stalls, the response waits in its register, the front
// end and queue keep taking requests until they fill, and the engine starts
// no new job until the waiting response has been taken.
// ----------------------------------------------------------------------------
module inflight_range_overlap_tracker_core import iror_pkg::*; #(
  parameter int unsigned TableEntries = TABLE_ENTRIES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  iror_in_if.sink    in_i,
  iror_out_if.source out_o
);

  logic front_valid;
  job_t front_job;
  logic front_ready;
  logic back_valid;
  job_t back_job;
  logic back_ready;

  iror_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .job_valid_o (front_valid),
    .job_o       (front_job),
    .job_ready_i (front_ready)
  );

  iror_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_data_i  (front_job),
    .push_ready_o (front_ready),
    .pop_valid_o  (back_valid),
    .pop_data_o   (back_job),
    .pop_ready_i  (back_ready)
  );

  iror_back #(
    .TableEntries (TableEntries)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (back_valid),
    .job_i       (back_job),
    .job_ready_o (back_ready),
    .out_o       (out_o)
  );

endmodule

// ===== bench/tb_inflight_range_overlap_tracker_core.sv =====
// ----------------------------------------------------------------------------
// Testbench for the in-flight range overlap tracker
// The bench opens with a short table of hand-picked requests. These cover an
// empty table, zero and maximum lengths, ranges that reach past the top of
// the address space, and release hits and misses. Rounds of random requests
// follow: fill, churn, scatter and drain. Every response beat is compared
// with a status worked out from the bench's own copy of the range table
// or, for typed rows, the row's own. Both sides of the bench idle at random.
// ----------------------------------------------------------------------------
module tb_inflight_range_overlap_tracker_core;
  import iror_pkg::*;

  localparam int unsigned ITEM_TARGET  = 1100;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned TAIL_CYCLES  = TABLE_ENTRIES_DEF + 8;
  localparam int unsigned DIRECTED_LEN = 21;

  typedef enum logic [1:0] {
    RK_FILL,
    RK_CHURN,
    RK_SCATTER,
    RK_DRAIN
  } round_kind_e;

  typedef struct {
    op_e                op;
    logic [START_W-1:0] offset;
    logic [LEN_W-1:0]   length;
    bit                 typed;
    status_e            want;
  } range_row_t;

  logic clk_i;
  logic rst_ni;

  iror_in_if  in_if ();
  iror_out_if out_if ();

  inflight_range_overlap_tracker_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  bit                 held_valid [TABLE_ENTRIES_DEF];
  logic [START_W-1:0] held_start [TABLE_ENTRIES_DEF];
  logic [LEN_W-1:0]   held_len   [TABLE_ENTRIES_DEF];
  status_e            pending_status [$];
  int unsigned        fault_count;
  int unsigned        sent_count;
  int unsigned        quiet_cycles;
  bit                 no_idle;

  range_row_t directed_rows [DIRECTED_LEN] = '{
    '{OP_RELEASE, 48'h0000_0000_0000, 25'h000_0000, 1'b1, ST_NOT_FOUND},
    '{OP_ACQUIRE, 48'h0000_0000_0000, 25'h000_0000, 1'b1, ST_OK},
    '{OP_ACQUIRE, 48'h0000_0000_0000, 25'h000_0001, 1'b0, ST_OK},
    '{OP_ACQUIRE, 48'h0000_0000_0001, 25'h000_0001, 1'b0, ST_OK},
    '{OP_ACQUIRE, 48'hFFFF_FFFF_FFFF, 25'h1FF_FFFF, 1'b1, ST_OK},
    '{OP_ACQUIRE, 48'hFFFF_FFFF_FFFE, 25'h000_0002, 1'b0, ST_OK},
    '{OP_ACQUIRE, 48'hFFFF_FFFF_FFFE, 25'h000_0001, 1'b0, ST_OK},
    '{OP_RELEASE, 48'hFFFF_FFFF_FFFF, 25'h1FF_FFFF, 1'b1, ST_OK},
    '{OP_RELEASE, 48'hFFFF_FFFF_FFFF, 25'h000_0000, 1'b1, ST_NOT_FOUND},
    '{OP_ACQUIRE, 48'h0000_1000_0000, 25'h100_0000, 1'b0, ST_OK},
    '{OP_ACQUIRE, 48'h0000_10FF_FFFF, 25'h000_0001, 1'b0, ST_OK},
    '{OP_ACQUIRE, 48'h0000_1100_0000, 25'h155_5555, 1'b0, ST_OK},
    '{OP_ACQUIRE, 48'h0000_0FFF_FFFF, 25'h0AA_AAAA, 1'b0, ST_OK},
    '{OP_RELEASE, 48'h0000_1000_0001, 25'h000_0000, 1'b0, ST_OK},
    '{OP_RELEASE, 48'h0000_1000_0000, 25'h1FF_FFFF, 1'b0, ST_OK},
    '{OP_ACQUIRE, 48'h0000_0FFF_FFFF, 25'h000_0002, 1'b0, ST_OK},
    '{OP_ACQUIRE, 48'hAAAA_AAAA_AAAA, 25'h0AA_AAAA, 1'b0, ST_OK},
    '{OP_ACQUIRE, 48'h5555_5555_5555, 25'h155_5555, 1'b0, ST_OK},
    '{OP_RELEASE, 48'h0000_0000_0000, 25'h155_5555, 1'b0, ST_OK},
    '{OP_RELEASE, 48'h0000_0000_0001, 25'h0AA_AAAA, 1'b0, ST_OK},
    '{OP_RELEASE, 48'hFFFF_FFFF_FFFE, 25'h000_0000, 1'b0, ST_OK}
  };

  function automatic status_e resolve_range_op(input op_e op,
                                               input logic [START_W-1:0] off,
                                               input logic [LEN_W-1:0] len);
    logic [END_W-1:0] stop_new;
    logic [END_W-1:0] stop_held;
    int               free_idx;
    free_idx = -1;
    if (op == OP_RELEASE) begin
      for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
        if (held_valid[i] && held_start[i] == off) begin
          held_valid[i] = 1'b0;
          return ST_OK;
        end
      end
      return ST_NOT_FOUND;
    end
    if (len == '0) begin
      len = LEN_W'(1);
    end
    stop_new = {1'b0, off} + END_W'(len);
    for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
      if (held_valid[i]) begin
        stop_held = {1'b0, held_start[i]} + END_W'(held_len[i]);
        if ({1'b0, held_start[i]} < stop_new && {1'b0, off} < stop_held) begin
          return ST_CONFLICT;
        end
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    if (free_idx < 0) begin
      return ST_FULL;
    end
    held_valid[free_idx] = 1'b1;
    held_start[free_idx] = off;
    held_len[free_idx]   = len;
    return ST_OK;
  endfunction

  function automatic bit pick_held_start(output logic [START_W-1:0] start);
    int idx [$];
    start = '0;
    foreach (held_valid[i]) begin
      if (held_valid[i]) begin
        idx.push_back(i);
      end
    end
    if (idx.size() == 0) begin
      return 1'b0;
    end
    start = held_start[idx[$urandom_range(0, idx.size() - 1)]];
    return 1'b1;
  endfunction

  function automatic logic [LEN_W-1:0] draw_length(input int unsigned span);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return LEN_W'(1) << (LEN_W - 1);
      3, 4:    return LEN_W'($urandom);
      default: return LEN_W'($urandom_range(1, span));
    endcase
  endfunction

  function automatic logic [START_W-1:0] draw_base();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1 - START_W'($urandom_range(0, 65535));
      default: return START_W'({$urandom, $urandom});
    endcase
  endfunction

  task automatic send_request(input op_e op, input logic [START_W-1:0] off,
                              input logic [LEN_W-1:0] len, input bit typed = 1'b0,
                              input status_e typed_status = ST_OK);
    int unsigned gap;
    status_e     predicted;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.op     <= op;
    in_if.offset <= off;
    in_if.length <= len;
    do @(posedge clk_i); while (!in_if.ready);
    predicted = resolve_range_op(op, off, len);
    pending_status.push_back(typed ? typed_status : predicted);
    sent_count++;
  endtask

  task automatic hold_until_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_status.size() != 0);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin : stimulus
    round_kind_e        kind;
    logic [START_W-1:0] base;
    logic [START_W-1:0] pick;
    logic [START_W-1:0] doomed [$];
    int unsigned        stride;
    int unsigned        count;
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.op     <= OP_ACQUIRE;
    in_if.offset <= '0;
    in_if.length <= '0;
    no_idle = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].op, directed_rows[i].offset, directed_rows[i].length,
                   directed_rows[i].typed, directed_rows[i].want);
    end
    hold_until_drained();

    while (sent_count < ITEM_TARGET) begin
      no_idle = ($urandom_range(0, 3) == 0);
      base    = draw_base();
      case ($urandom_range(0, 9))
        0, 1, 2: kind = RK_FILL;
        3, 4, 5: kind = RK_CHURN;
        6:       kind = RK_SCATTER;
        default: kind = RK_DRAIN;
      endcase
      case (kind)
        RK_FILL: begin
          stride = $urandom_range(1, 32);
          for (int k = 0; k < TABLE_ENTRIES_DEF + 6; k++) begin
            send_request(OP_ACQUIRE, base + START_W'(k * stride),
                         LEN_W'($urandom_range(0, stride)));
          end
          repeat (4) begin
            send_request(OP_ACQUIRE, base + START_W'($urandom_range(0, 8 * stride)),
                         draw_length(stride));
          end
        end
        RK_CHURN: begin
          count = $urandom_range(20, 60);
          repeat (count) begin
            if ($urandom_range(0, 9) < 4) begin
              if ($urandom_range(0, 9) < 7 && pick_held_start(pick)) begin
                send_request(OP_RELEASE, pick, LEN_W'($urandom));
              end else begin
                send_request(OP_RELEASE, base + START_W'($urandom_range(0, 2047)),
                             LEN_W'($urandom));
              end
            end else begin
              send_request(OP_ACQUIRE, base + START_W'($urandom_range(0, 2047)),
                           draw_length(256));
            end
          end
        end
        RK_SCATTER: begin
          count = $urandom_range(10, 30);
          repeat (count) begin
            if ($urandom_range(0, 1) == 0) begin
              send_request(OP_ACQUIRE, START_W'({$urandom, $urandom}), draw_length(1 << 20));
            end else if ($urandom_range(0, 1) == 0 && pick_held_start(pick)) begin
              send_request(OP_RELEASE, pick, LEN_W'($urandom));
            end else begin
              send_request(OP_RELEASE, START_W'({$urandom, $urandom}), LEN_W'($urandom));
            end
          end
        end
        default: begin
          doomed.delete();
          foreach (held_valid[i]) begin
            if (held_valid[i]) begin
              doomed.push_back(held_start[i]);
            end
          end
          doomed.shuffle();
          foreach (doomed[j]) begin
            if ($urandom_range(0, 4) == 0) begin
              send_request(OP_RELEASE, doomed[j] + START_W'(1), LEN_W'($urandom));
            end
            send_request(OP_RELEASE, doomed[j], LEN_W'($urandom));
          end
          repeat (2) begin
            send_request(OP_ACQUIRE, base + START_W'($urandom_range(0, 255)), draw_length(64));
          end
        end
      endcase
      if ($urandom_range(0, 4) == 0) begin
        hold_until_drained();
      end
    end

    in_if.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : response_sink
    int unsigned stall;
    status_e     want;
    out_if.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
      if (pending_status.size() == 0) begin
        $error("status beat with no request outstanding, actual %0d", out_if.status);
        fault_count++;
      end else begin
        want = pending_status.pop_front();
        if (out_if.status !== want) begin
          $error("status mismatch: expected %0d, actual %0d", want, out_if.status);
          fault_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

// ===== files.f =====
rtl/iror_pkg.sv
rtl/iror_in_if.sv
rtl/iror_out_if.sv
rtl/iror_front.sv
rtl/iror_queue.sv
rtl/iror_back.sv
rtl/inflight_range_overlap_tracker_core.sv
bench/tb_inflight_range_overlap_tracker_core.sv
